### src/hrlec_pkg.sv
// Shared types, constants and the hop code-length table of the hop run-length coder.
// No dependencies; the coder, the result register, the top level and the bench import this package.
`timescale 1ns / 1ps

package hrlec_pkg;

  localparam int WORD_BITS = 32;
  localparam int BYTES_W   = 12;

  localparam logic [4:0]  RUN_ENTRY_NULLS = 5'd7;
  localparam logic [4:0]  ESC_NARROW      = 5'd15;
  localparam logic [4:0]  ESC_WIDE        = 5'd31;
  localparam logic [11:0] BYTE_MAX        = 12'd4095;
  localparam logic [3:0]  NULL_HOP        = 4'd4;
  localparam logic [3:0]  MAX_HOP         = 4'd8;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_RUN5  = 3'b010,
    MODE_RUN6  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic [2:0]           valid_bytes;
    logic [BYTES_W-1:0]   line_bytes;
    logic                 line_done;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } coder_out_t;

  // Code length per hop symbol: 9,7,5,3,1,2,4,6,8.
  function automatic logic [3:0] code_len(input logic [3:0] h);
    logic [3:0] len;
    unique case (h)
      4'd0:    len = 4'd9;
      4'd1:    len = 4'd7;
      4'd2:    len = 4'd5;
      4'd3:    len = 4'd3;
      4'd4:    len = 4'd1;
      4'd5:    len = 4'd2;
      4'd6:    len = 4'd4;
      4'd7:    len = 4'd6;
      default: len = 4'd8;
    endcase
    return len;
  endfunction

endpackage

### src/hrlec_in_if.sv
// Symbol channel: valid/ready handshake carrying one hop symbol and its end-of-line mark.
// Depends on nothing.
`timescale 1ns / 1ps

interface hrlec_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] hop;
  logic       last_in_line;

  modport source (output valid, output hop, output last_in_line, input ready);
  modport sink   (input valid, input hop, input last_in_line, output ready);
endinterface

### src/hrlec_out_if.sv
// Word channel: valid/ready handshake carrying one packed word with its byte counts.
// Depends on nothing.
`timescale 1ns / 1ps

interface hrlec_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;
  logic [2:0]  valid_bytes;
  logic [11:0] line_bytes;
  logic        line_done;

  modport source (output valid, output packed_word, output valid_bytes,
                  output line_bytes, output line_done, input ready);
  modport sink   (input valid, input packed_word, input valid_bytes,
                  input line_bytes, input line_done, output ready);
endinterface

### src/hrlec_coder.sv
// Coder state, symbol-to-bits mapping and 32-bit MSB-first packer for one symbol per cycle while advance is high.
// Depends on hrlec_pkg.
`timescale 1ns / 1ps

module hrlec_coder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [3:0]           hop,
  input  logic                 last_in_line,
  output hrlec_pkg::coder_out_t results
);
  import hrlec_pkg::*;

  mode_t       mode, mode_next;
  logic [4:0]  null_run, null_run_next;
  logic [31:0] pack_buffer, buf_next;
  logic [5:0]  free_bits, free_next;
  logic [11:0] byte_total, bt_word, bt_tail;

  logic [3:0]  hop_s, len, fld_w, n, rem;
  logic        is_null, full, flush;
  logic [4:0]  nr_inc, nr_plain, esc;
  logic [13:0] v;
  logic [31:0] word0;
  logic [5:0]  used;
  logic [2:0]  tail_bytes;
  res_t        word_res, tail_res;

  function automatic logic [11:0] sat_add(input logic [11:0] a, input logic [2:0] b);
    logic [12:0] s;
    s = {1'b0, a} + {10'b0, b};
    return (s > {1'b0, BYTE_MAX}) ? BYTE_MAX : s[11:0];
  endfunction

  // Bits this symbol appends: count n (0..14), value v right aligned.
  always_comb begin
    hop_s         = (hop > MAX_HOP) ? MAX_HOP : hop;
    is_null       = (hop_s == NULL_HOP);
    len           = code_len(hop_s);
    nr_inc        = null_run + 5'd1;
    fld_w         = (mode == MODE_RUN6) ? 4'd6 : 4'd5;
    esc           = (mode == MODE_RUN6) ? ESC_WIDE : ESC_NARROW;
    nr_plain      = is_null ? nr_inc : 5'd0;
    n             = 4'd0;
    v             = 14'd0;
    mode_next     = mode;
    null_run_next = null_run;
    unique case (mode) inside
      MODE_RUN5, MODE_RUN6: begin
        if (is_null) begin
          if (nr_inc == esc) begin
            n             = 4'd1;
            v             = 14'd1;
            null_run_next = 5'd0;
            mode_next     = MODE_RUN6;
          end else begin
            null_run_next = nr_inc;
            if (last_in_line) begin
              n = fld_w;
              v = {9'b0, nr_inc};
            end
          end
        end else begin
          // run count, then the symbol code minus its leading zero
          n             = fld_w + len - 4'd1;
          v             = ({9'b0, null_run} << (len - 4'd1)) | 14'd1;
          null_run_next = 5'd0;
          mode_next     = MODE_PLAIN;
        end
      end
      default: begin
        n = len;
        v = 14'd1;
        if (nr_plain == RUN_ENTRY_NULLS) begin
          mode_next     = MODE_RUN5;
          null_run_next = 5'd0;
        end else begin
          mode_next     = MODE_PLAIN;
          null_run_next = nr_plain;
        end
      end
    endcase
  end

  // Pack, emit a full word, flush the tail on line end.
  always_comb begin
    full  = (n != 4'd0) && ({2'b0, n} >= free_bits);
    rem   = n - free_bits[3:0];
    word0 = (pack_buffer << free_bits) | ({18'b0, v} >> rem);
    if (full) begin
      buf_next  = {18'b0, v & ~(14'h3fff << rem)};
      free_next = 6'd32 - {2'b0, rem};
    end else if (n != 4'd0) begin
      buf_next  = (pack_buffer << n) | {18'b0, v};
      free_next = free_bits - {2'b0, n};
    end else begin
      buf_next  = pack_buffer;
      free_next = free_bits;
    end
    flush      = last_in_line && (free_next != 6'd32);
    used       = 6'd32 - free_next;
    tail_bytes = 3'((7'({1'b0, used}) + 7'd7) >> 3);
    bt_word    = full ? sat_add(byte_total, 3'd4) : byte_total;
    bt_tail    = sat_add(bt_word, tail_bytes);

    word_res.packed_word = word0;
    word_res.valid_bytes = 3'd4;
    word_res.line_bytes  = bt_word;
    word_res.line_done   = last_in_line && !flush;

    if (flush) begin
      tail_res.packed_word = buf_next << free_next;
      tail_res.valid_bytes = tail_bytes;
      tail_res.line_bytes  = bt_tail;
    end else begin
      tail_res.packed_word = 32'd0;
      tail_res.valid_bytes = 3'd0;
      tail_res.line_bytes  = bt_word;
    end
    tail_res.line_done = 1'b1;

    if (full) begin
      results.first  = word_res;
      results.second = tail_res;
      results.count  = flush ? 2'd2 : 2'd1;
    end else begin
      results.first  = tail_res;
      results.second = tail_res;
      results.count  = last_in_line ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      null_run    <= 5'd0;
      pack_buffer <= 32'd0;
      free_bits   <= 6'd32;
      byte_total  <= 12'd0;
    end else if (advance) begin
      if (last_in_line) begin
        mode        <= MODE_PLAIN;
        null_run    <= 5'd0;
        pack_buffer <= 32'd0;
        free_bits   <= 6'd32;
        byte_total  <= 12'd0;
      end else begin
        mode        <= mode_next;
        null_run    <= null_run_next;
        pack_buffer <= buf_next;
        free_bits   <= free_next;
        byte_total  <= bt_word;
      end
    end
  end

endmodule

### src/hrlec_result_buf.sv
// Two-slot result register: takes up to two results of one symbol, hands them out one beat at a time.
// Depends on hrlec_pkg and the word channel interface.
`timescale 1ns / 1ps

module hrlec_result_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  hrlec_pkg::coder_out_t results,
  output logic                  space,
  hrlec_out_if.source           words
);
  import hrlec_pkg::*;

  res_t       slot0, slot1;
  logic [1:0] count;
  logic       pop;

  assign pop   = (count != 2'd0) && words.ready;
  // buffer is empty or drains this cycle, so a new pair may land
  assign space = (count == 2'd0) || ((count == 2'd1) && words.ready);

  assign words.valid       = (count != 2'd0);
  assign words.packed_word = slot0.packed_word;
  assign words.valid_bytes = slot0.valid_bytes;
  assign words.line_bytes  = slot0.line_bytes;
  assign words.line_done   = slot0.line_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= results.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= results.first;
      slot1 <= results.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

### src/hop_run_length_entropy_coder_core.sv
// Hop run-length entropy coder, top level.
// Path: an accepted symbol passes the input register and then the result register before its
//   first result beat is valid; a result register without space holds it in the input register.
// Throughput: one symbol per cycle while each symbol yields at most one beat and the word
//   sink keeps ready high; a symbol that yields two beats (word plus line flush) holds the
//   input until its first beat has left, as the result register hands out one beat per cycle while the sink is ready.
// Reset: rst (synchronous) clears the input register, the coder state and the result slots.
`timescale 1ns / 1ps

module hop_run_length_entropy_coder_core (
  input  logic        clk,
  input  logic        rst,
  hrlec_in_if.sink    symbols,
  hrlec_out_if.source words
);
  import hrlec_pkg::*;

  // Input register: one symbol waits here until the result register can take its beats.
  logic       in_valid;
  logic [3:0] in_hop;
  logic       in_last;

  logic       space;
  logic       advance;
  coder_out_t results;

  // Advance the held symbol only when the result slots are empty or drain this cycle.
  assign advance       = in_valid && space;
  // Take a new beat whenever the register is empty or moves on in this cycle.
  assign symbols.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (symbols.valid && symbols.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  // Payload holds while stalled; no reset needed.
  always_ff @(posedge clk) begin
    if (symbols.valid && symbols.ready) begin
      in_hop  <= symbols.hop;
      in_last <= symbols.last_in_line;
    end
  end

  // Coder: mode, run count and packer state update once per advanced symbol.
  hrlec_coder u_coder (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .hop          (in_hop),
    .last_in_line (in_last),
    .results      (results)
  );

  // Result register: zero, one or two beats per symbol, drained one per cycle while the sink is ready.
  hrlec_result_buf u_result_buf (
    .clk     (clk),
    .rst     (rst),
    .load    (advance),
    .results (results),
    .space   (space),
    .words   (words)
  );

endmodule

### src/hrlec_checker.sv
// Port-level checks of the hop run-length coder, bound to the top level.
// Depends on the top level's word channel signals only.
`timescale 1ns / 1ps

module hrlec_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [2:0]  out_bytes,
  input logic [11:0] out_line_bytes,
  input logic        out_done
);

  // A stalled beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_bytes)
      && $stable(out_line_bytes) && $stable(out_done))
    else $error("stalled result beat changed");

  // Reset empties the result slots.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present right after reset");

  // Every beat that does not close a line is a full word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_done |-> out_bytes == 3'd4)
    else $error("partial word before line end");

  // A beat carries between one and four bytes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_bytes != 3'd0 && out_bytes <= 3'd4)
    else $error("byte count out of range");

  // Within a line the running byte total never falls.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_done ##1 out_valid
      |-> out_line_bytes >= $past(out_line_bytes))
    else $error("running byte total decreased");

endmodule

bind hop_run_length_entropy_coder_core hrlec_checker u_hrlec_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (words.valid),
  .out_ready      (words.ready),
  .out_word       (words.packed_word),
  .out_bytes      (words.valid_bytes),
  .out_line_bytes (words.line_bytes),
  .out_done       (words.line_done)
);

### bench/tb_top.sv
// Self-checking bench for the hop run-length entropy coder core.
// Drives hop symbols over the symbol channel, predicts packed words, checks the word channel.
// Depends on hrlec_pkg, hrlec_in_if, hrlec_out_if and hop_run_length_entropy_coder_core.
`timescale 1ns / 1ps

module tb_top;
  import hrlec_pkg::*;

  // Cycles without any beat on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Cycles to watch for stray beats once every expected word has arrived.
  localparam int DRAIN_CYCLES = 20;
  // Code length per symbol, symbol 0 in the low nibble: 9,7,5,3,1,2,4,6,8.
  localparam logic [35:0] LEN_TABLE =
    {4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9};

  logic clk = 1'b0;
  logic rst;

  hrlec_in_if  sym_if ();
  hrlec_out_if word_if ();

  hop_run_length_entropy_coder_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_if),
    .words   (word_if)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Coder model state: mirrors what the core keeps between symbols.
  // ---------------------------------------------------------------------------
  mode_t       coder_mode;
  logic [4:0]  null_count;
  logic        wide_field;
  logic [31:0] bit_acc;
  int          free_slots;
  logic [11:0] bytes_sent;

  res_t step_words[$];     // words caused by the symbol being coded
  res_t pending_words[$];  // words predicted but not yet seen on the word channel
  int   mismatches = 0;
  bit   in_quiet   = 1'b0; // no input gaps while set

  task automatic clear_coder();
    coder_mode = MODE_PLAIN;
    null_count = '0;
    wide_field = 1'b0;
    bit_acc    = '0;
    free_slots = 32;
    bytes_sent = '0;
  endtask

  // Account the bytes of one word against the line total, saturating at the ceiling.
  task automatic emit_word(input logic [31:0] word, input int nbytes, input bit done);
    res_t r;
    int   total;
    if (step_words.size() < 2) begin
      total      = int'(bytes_sent) + nbytes;
      bytes_sent = (total > int'(BYTE_MAX)) ? BYTE_MAX : total[11:0];
      r.packed_word = word;
      r.valid_bytes = nbytes[2:0];
      r.line_bytes  = bytes_sent;
      r.line_done   = done;
      step_words.push_back(r);
    end
  endtask

  // Append n bits of v, MSB first; a full word leaves as a 4-byte beat.
  task automatic append_bits(input int n, input int v);
    logic [31:0] bits;
    int          spill;
    bits = v & ((1 << n) - 1);
    if (n < free_slots) begin
      bit_acc    = (bit_acc << n) | bits;
      free_slots = free_slots - n;
    end else begin
      spill = n - free_slots;
      emit_word((bit_acc << free_slots) | (bits >> spill), 4, 1'b0);
      bit_acc    = bits & ((1 << spill) - 1);
      free_slots = 32 - spill;
    end
  endtask

  // Code one accepted symbol; the words it causes land in step_words.
  task automatic code_symbol(input logic [3:0] hop_in, input bit last);
    logic [3:0] h;
    logic [4:0] esc;
    int         len;
    res_t       tail;
    step_words.delete();
    h   = (hop_in > MAX_HOP) ? MAX_HOP : hop_in;
    len = int'(LEN_TABLE[h*4 +: 4]);
    if (h == NULL_HOP) null_count = null_count + 5'd1;

    if (coder_mode == MODE_RUN5 || coder_mode == MODE_RUN6) begin
      esc = (coder_mode == MODE_RUN6) ? ESC_WIDE : ESC_NARROW;
      if (h == NULL_HOP && null_count == esc) begin
        // Escape: one bit, then the run field widens to 6 bits.
        append_bits(1, 1);
        null_count = '0;
        coder_mode = MODE_RUN6;
        wide_field = 1'b1;
      end else if (h != NULL_HOP) begin
        // Close the run: count, then the code with one leading zero dropped.
        append_bits(5 + int'(wide_field), int'(null_count));
        append_bits(len - 1, 1);
        null_count = '0;
        coder_mode = MODE_PLAIN;
        wide_field = 1'b0;
      end
    end else begin
      append_bits(len, 1);
      if (h != NULL_HOP) null_count = '0;
      if (null_count == RUN_ENTRY_NULLS) begin
        coder_mode = MODE_RUN5;
        wide_field = 1'b0;
        null_count = '0;
      end
    end

    if (last) begin
      if (null_count != '0 && (coder_mode == MODE_RUN5 || coder_mode == MODE_RUN6))
        append_bits(5 + int'(wide_field), int'(null_count));
      if (free_slots < 32) begin
        emit_word(bit_acc << free_slots, (32 - free_slots + 7) >> 3, 1'b1);
      end else if (step_words.size() > 0) begin
        tail = step_words.pop_back();
        tail.line_done = 1'b1;
        step_words.push_back(tail);
      end else begin
        emit_word('0, 0, 1'b1);
      end
      clear_coder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare every accepted word beat with the oldest prediction, field by field.
  always @(posedge clk) begin : check_words
    res_t want;
    if (!rst && word_if.valid && word_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("word beat with none expected", word_if.packed_word, '0);
      end else begin
        want = pending_words.pop_front();
        if (word_if.packed_word !== want.packed_word)
          report_mismatch("packed_word", word_if.packed_word, want.packed_word);
        if (word_if.valid_bytes !== want.valid_bytes)
          report_mismatch("valid_bytes", 32'(word_if.valid_bytes), 32'(want.valid_bytes));
        if (word_if.line_bytes !== want.line_bytes)
          report_mismatch("line_bytes", 32'(word_if.line_bytes), 32'(want.line_bytes));
        if (word_if.line_done !== want.line_done)
          report_mismatch("line_done", 32'(word_if.line_done), 32'(want.line_done));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling on both sides: mostly none, some short, a few long.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Word sink: alternate ready stretches with stalls; now and then a long clean stretch.
  initial begin : word_sink
    int stall;
    word_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      word_if.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
      else repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        word_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Hang detector: end the run when no beat moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((sym_if.valid && sym_if.ready) || (word_if.valid && word_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[hop_run_length_entropy_coder_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Symbol source
  // ---------------------------------------------------------------------------
  // Drive one symbol and hold it until accepted. A fixed expectation, where given,
  // replaces the predicted word; the model state still advances.
  task automatic send_symbol(input logic [3:0] h, input bit last,
                             input bit fixed, input res_t fixed_word);
    int gap;
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      sym_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sym_if.valid        <= 1'b1;
    sym_if.hop          <= h;
    sym_if.last_in_line <= last;
    do @(posedge clk); while (!sym_if.ready);
    code_symbol(h, last);
    if (fixed) pending_words.push_back(fixed_word);
    else foreach (step_words[i]) pending_words.push_back(step_words[i]);
  endtask

  function automatic logic [3:0] non_null_hop();
    logic [3:0] h;
    h = 4'($urandom_range(0, 15));
    while (h == NULL_HOP) h = 4'($urandom_range(0, 15));
    return h;
  endfunction

  // One random line. Most lines are null runs of lengths that reach the run mode
  // entry, the narrow escape (7+15) and the wide escapes (7+15+31, +31), each closed
  // by a non-null hop; the rest is noise and runs cut short.
  task automatic random_line(inout int sent);
    logic [3:0] line_hops[$];
    int         segs;
    int         nulls;
    int         k;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) line_hops.push_back(4'($urandom_range(0, 15)));
    end else begin
      segs = $urandom_range(1, 4);
      for (k = 0; k < segs; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: nulls = $urandom_range(0, 6);
          8, 9, 10, 11:           nulls = $urandom_range(7, 12);
          12, 13, 14:             nulls = $urandom_range(20, 24);
          15:                     nulls = $urandom_range(51, 56);
          16:                     nulls = $urandom_range(83, 86);
          default: begin
            nulls = 0;
            repeat ($urandom_range(1, 5)) line_hops.push_back(4'($urandom_range(0, 15)));
          end
        endcase
        repeat (nulls) line_hops.push_back(NULL_HOP);
        // Leave the last run open now and then so the pending count goes out at line end.
        if (k < segs - 1 || $urandom_range(0, 2) != 0) line_hops.push_back(non_null_hop());
      end
      if (line_hops.size() == 0) line_hops.push_back(non_null_hop());
    end
    in_quiet = ($urandom_range(0, 3) == 0);
    foreach (line_hops[i])
      send_symbol(line_hops[i], i == line_hops.size() - 1, 1'b0, '0);
    sent += line_hops.size();
  endtask

  // Directed rows: symbol, end of line, and a fixed expectation where obvious.
  typedef struct {
    logic [3:0] hop;
    bit         last;
    bit         fixed;
    res_t       word;
  } stim_row_t;

  stim_row_t directed_rows[$];

  task automatic add_row(input logic [3:0] h, input bit last, input bit fixed,
                         input res_t word);
    stim_row_t row;
    row.hop   = h;
    row.last  = last;
    row.fixed = fixed;
    row.word  = word;
    directed_rows.push_back(row);
  endtask

  initial begin : stimulus
    int sent;
    int n;
    clear_coder();
    rst                 <= 1'b1;
    sym_if.valid        <= 1'b0;
    sym_if.hop          <= '0;
    sym_if.last_in_line <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // One-symbol lines straight after reset: shortest code, longest codes,
    // and out-of-range hops that saturate to symbol 8.
    add_row(NULL_HOP, 1'b1, 1'b1, {32'h8000_0000, 3'd1, 12'd1, 1'b1});
    add_row(4'd0,     1'b1, 1'b1, {32'h0080_0000, 3'd2, 12'd2, 1'b1});
    add_row(MAX_HOP,  1'b1, 1'b1, {32'h0100_0000, 3'd1, 12'd1, 1'b1});
    add_row(4'd15,    1'b1, 1'b1, {32'h0100_0000, 3'd1, 12'd1, 1'b1});
    add_row(4'd9,     1'b1, 1'b1, {32'h0100_0000, 3'd1, 12'd1, 1'b1});
    // Every symbol once in one line.
    for (n = 0; n <= 8; n++) add_row(n[3:0], n == 8, 1'b0, '0);
    // Enter run mode and end the line inside the run: pending count at line end.
    repeat (10) add_row(NULL_HOP, 1'b0, 1'b0, '0);
    directed_rows[directed_rows.size() - 1].last = 1'b1;

    @(posedge clk);
    foreach (directed_rows[i])
      send_symbol(directed_rows[i].hop, directed_rows[i].last,
                  directed_rows[i].fixed, directed_rows[i].word);

    // Random lines until roughly 700 symbols have gone in.
    sent = 0;
    while (sent < 700) random_line(sent);
    sym_if.valid <= 1'b0;

    // Drain, then watch a little longer for stray beats.
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("[hop_run_length_entropy_coder_core] OK");
    else
      $display("[hop_run_length_entropy_coder_core] ERROR");
    $finish;
  end

endmodule
